// ===== rtl/point_scale_rotate_translate_unit_assert.svh =====
// Assertion macros shared by the point transform RTL.
`ifndef POINT_SCALE_ROTATE_TRANSLATE_UNIT_ASSERT_SVH
`define POINT_SCALE_ROTATE_TRANSLATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSRT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSRT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psrt_pkg.sv =====
// Shared constants, types and tables of the point transform.
package psrt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TRIG_STEPS = 24;

  localparam int COORD_W   = 32;
  localparam int SCALE_W   = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;

  // Angle wrap: bias the angle positive, then restoring subtract of 360 deg.
  localparam longint ANGLE_FULL    = longint'(360) << FRAC_BITS;
  localparam longint ANGLE_HALF    = longint'(180) << FRAC_BITS;
  localparam longint ANGLE_QUARTER = longint'(90) << FRAC_BITS;
  localparam longint WRAP_TURNS    = ((longint'(1) << 31) + ANGLE_FULL - 1) / ANGLE_FULL;
  localparam longint WRAP_BIAS     = WRAP_TURNS * ANGLE_FULL;
  localparam int     WRAP_STEPS    = $clog2(2 * WRAP_TURNS + 2);
  localparam int     WRAP_W        = 35;
  localparam int     ANG_W         = FRAC_BITS + 10;

  // CORDIC
  localparam int CORDIC_W = 34;
  localparam int Z_W      = 33;
  localparam int DEG_W    = 28;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [DEG_W-1:0]    DEG_TO_RAD  = 28'sd74961321;
  localparam logic signed [COORD_W-1:0]  COS_RESET   = 32'sd1073741824;
  localparam logic signed [COORD_W-1:0]  SIN_RESET   = 32'sd0;

  // Datapath widths
  localparam int SPLIT  = 24;
  localparam int PROD_W = 2 * COORD_W;
  localparam int SX_W   = PROD_W - FRAC_BITS;
  localparam int AH_W   = SX_W - SPLIT;
  localparam int AL_W   = SPLIT + 1;
  localparam int HP_W   = AH_W + COORD_W;
  localparam int LP_W   = AL_W + COORD_W;
  localparam int HI_W   = HP_W + 1;
  localparam int LO_W   = LP_W + 1;
  localparam int T_W    = HI_W + 1;
  localparam int TP_W   = T_W + 1;
  localparam int Q_W    = TP_W - 6;
  localparam int V_W    = Q_W + 1;

  typedef struct packed {
    logic                       busy;
    logic signed [COORD_W-1:0]  cos_q30;
    logic signed [COORD_W-1:0]  sin_q30;
  } trig_t;

  typedef struct packed {
    logic        [SCALE_W-1:0]  scale_x;
    logic        [SCALE_W-1:0]  scale_y;
    logic signed [COORD_W-1:0]  offset_x;
    logic signed [COORD_W-1:0]  offset_y;
    logic signed [COORD_W-1:0]  cos_q30;
    logic signed [COORD_W-1:0]  sin_q30;
  } coef_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/psrt_point_if.sv =====
// Input point channel: valid/ready plus point coordinates.
interface psrt_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/psrt_result_if.sv =====
// Result channel: valid/ready plus transformed coordinates and overflow.
interface psrt_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic               overflow;

  modport source (output valid, output result_x, output result_y, output overflow,
                  input ready);
  modport sink   (input valid, input result_x, input result_y, input overflow,
                  output ready);
endinterface

// ===== rtl/psrt_trig.sv =====
// Sine/cosine unit: angle wrap by restoring subtract, then iterative CORDIC.
module psrt_trig (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [psrt_pkg::COORD_W-1:0]   angle,
  output psrt_pkg::trig_t                trig
);
  import psrt_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WRAP = 3'd1;
  localparam logic [2:0] ST_FOLD = 3'd2;
  localparam logic [2:0] ST_CONV = 3'd3;
  localparam logic [2:0] ST_ROT  = 3'd4;

  localparam int STEP_W = (WRAP_STEPS > 1) ? $clog2(WRAP_STEPS) : 1;
  localparam int CONV_W = ANG_W + DEG_W;

  logic [2:0]                  state;
  logic [STEP_W-1:0]           wrap_step;
  logic [WRAP_W-1:0]           wrap_acc;
  logic signed [ANG_W-1:0]     ang;
  logic                        neg;
  logic signed [Z_W-1:0]       z;
  logic signed [CORDIC_W-1:0]  x;
  logic signed [CORDIC_W-1:0]  y;
  logic [4:0]                  iter;

  logic [WRAP_W-1:0]           wrap_sub;
  logic signed [ANG_W-1:0]     fold_a0;
  logic signed [ANG_W-1:0]     fold_a1;
  logic signed [ANG_W-1:0]     fold_ang;
  logic                        fold_neg;
  logic signed [CONV_W-1:0]    conv_prod;
  logic signed [CONV_W-1:0]    conv_sum;
  logic signed [CORDIC_W-1:0]  dx;
  logic signed [CORDIC_W-1:0]  dy;
  logic signed [Z_W-1:0]       atan_v;
  logic signed [CORDIC_W-1:0]  x_fin;
  logic signed [CORDIC_W-1:0]  y_fin;

  always_comb begin
    wrap_sub = WRAP_W'(ANGLE_FULL) << wrap_step;

    // wrapped angle into [-180, 180), then fold to [-90, 90]
    fold_a0 = ANG_W'(wrap_acc);
    fold_a1 = (fold_a0 >= ANG_W'(ANGLE_HALF)) ? fold_a0 - ANG_W'(ANGLE_FULL) : fold_a0;
    fold_ang = fold_a1;
    fold_neg = 1'b0;
    if (fold_a1 > ANG_W'(ANGLE_QUARTER)) begin
      fold_ang = fold_a1 - ANG_W'(ANGLE_HALF);
      fold_neg = 1'b1;
    end else if (fold_a1 < -ANG_W'(ANGLE_QUARTER)) begin
      fold_ang = fold_a1 + ANG_W'(ANGLE_HALF);
      fold_neg = 1'b1;
    end

    // degrees to radians Q2.30, round half up
    conv_prod = CONV_W'(ang) * CONV_W'(DEG_TO_RAD);
    conv_sum  = conv_prod + CONV_W'(longint'(1) << (FRAC_BITS + 1));

    dx     = y >>> iter;
    dy     = x >>> iter;
    atan_v = Z_W'(signed'({1'b0, atan_q30(iter)}));

    x_fin = neg ? -x : x;
    y_fin = neg ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (start) begin
      state     <= ST_WRAP;
      wrap_step <= STEP_W'(WRAP_STEPS - 1);
      wrap_acc  <= {{(WRAP_W-COORD_W){angle[COORD_W-1]}}, angle} + WRAP_W'(WRAP_BIAS);
    end else begin
      case (state)
        ST_WRAP: begin
          if (wrap_acc >= wrap_sub) begin
            wrap_acc <= wrap_acc - wrap_sub;
          end
          if (wrap_step == '0) begin
            state <= ST_FOLD;
          end else begin
            wrap_step <= wrap_step - 1'b1;
          end
        end
        ST_FOLD: begin
          ang   <= fold_ang;
          neg   <= fold_neg;
          state <= ST_CONV;
        end
        ST_CONV: begin
          z     <= Z_W'(conv_sum >>> (FRAC_BITS + 2));
          x     <= CORDIC_GAIN;
          y     <= '0;
          iter  <= '0;
          state <= ST_ROT;
        end
        ST_ROT: begin
          if (!z[Z_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_v;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_v;
          end
          if (iter == 5'(TRIG_STEPS - 1)) begin
            state <= ST_IDLE;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture once the final micro-rotation is in x/y.
  logic done;
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= !start && state == ST_ROT && iter == 5'(TRIG_STEPS - 1);
    end
  end

  logic signed [COORD_W-1:0] cos_out;
  logic signed [COORD_W-1:0] sin_out;
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_out <= COS_RESET;
      sin_out <= SIN_RESET;
    end else if (done) begin
      cos_out <= COORD_W'(x_fin);
      sin_out <= COORD_W'(y_fin);
    end
  end

  assign trig.busy    = (state != ST_IDLE) || done;
  assign trig.cos_q30 = cos_out;
  assign trig.sin_q30 = sin_out;

endmodule

// ===== rtl/psrt_datapath.sv =====
// Six-stage point pipeline: scale, round, partial products, sums, merge, offset/saturate.
module psrt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hold,
  input  psrt_pkg::coef_t      coef,
  psrt_point_if.sink           point,
  psrt_result_if.source        result
);
  import psrt_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [V_W-1:0] v,
                                                      output logic ovf);
    logic signed [COORD_W-1:0] r;
    ovf = 1'b0;
    r   = COORD_W'(v);
    if (v > V_W'(longint'(32'h7FFF_FFFF))) begin
      ovf = 1'b1;
      r   = 32'sh7FFF_FFFF;
    end else if (v < -V_W'(longint'(1) << 31)) begin
      ovf = 1'b1;
      r   = 32'sh8000_0000;
    end
    return r;
  endfunction

  logic v1, v2, v3, v4, v5;
  logic a1, a2, a3, a4, a5, a6;
  logic take;

  // stage registers
  logic signed [PROD_W-1:0] s1_px;
  logic signed [PROD_W-1:0] s1_py;
  logic signed [SX_W-1:0]   s2_sx;
  logic signed [SX_W-1:0]   s2_sy;
  logic signed [HP_W-1:0]   s3_hxc, s3_hxs, s3_hyc, s3_hys;
  logic signed [LP_W-1:0]   s3_lxc, s3_lxs, s3_lyc, s3_lys;
  logic signed [HI_W-1:0]   s4_hix, s4_hiy;
  logic signed [LO_W-1:0]   s4_lox, s4_loy;
  logic signed [T_W-1:0]    s5_tx, s5_ty;

  // combinational
  logic signed [PROD_W-1:0] rnd_px, rnd_py;
  logic signed [AH_W-1:0]   ah_x, ah_y;
  logic signed [AL_W-1:0]   al_x, al_y;
  logic signed [TP_W-1:0]   tr_x, tr_y;
  logic signed [V_W-1:0]    sum_x, sum_y;
  logic signed [COORD_W-1:0] sat_x, sat_y;
  logic                     ovf_x, ovf_y;

  assign a6 = !result.valid || result.ready;
  assign a5 = !v5 || a6;
  assign a4 = !v4 || a5;
  assign a3 = !v3 || a4;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;

  assign point.ready = a1 && !hold;
  assign take        = point.valid && point.ready;

  always_comb begin
    rnd_px = s1_px + PROD_W'(longint'(1) << (FRAC_BITS - 1));
    rnd_py = s1_py + PROD_W'(longint'(1) << (FRAC_BITS - 1));
    ah_x   = s2_sx[SX_W-1:SPLIT];
    ah_y   = s2_sy[SX_W-1:SPLIT];
    al_x   = {1'b0, s2_sx[SPLIT-1:0]};
    al_y   = {1'b0, s2_sy[SPLIT-1:0]};
    tr_x   = TP_W'(s5_tx) + TP_W'(32);
    tr_y   = TP_W'(s5_ty) + TP_W'(32);
    sum_x  = V_W'(Q_W'(tr_x >>> 6)) + V_W'(coef.offset_x);
    sum_y  = V_W'(Q_W'(tr_y >>> 6)) + V_W'(coef.offset_y);
    sat_x  = sat32(sum_x, ovf_x);
    sat_y  = sat32(sum_y, ovf_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (a1) v1 <= take;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
      if (a4) v4 <= v3;
      if (a5) v5 <= v4;
      if (a6) result.valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (a1) begin
      s1_px <= PROD_W'(point.point_x) * PROD_W'(signed'({1'b0, coef.scale_x}));
      s1_py <= PROD_W'(point.point_y) * PROD_W'(signed'({1'b0, coef.scale_y}));
    end
    if (a2) begin
      s2_sx <= SX_W'(rnd_px >>> FRAC_BITS);
      s2_sy <= SX_W'(rnd_py >>> FRAC_BITS);
    end
    if (a3) begin
      s3_hxc <= HP_W'(ah_x) * HP_W'(coef.cos_q30);
      s3_hxs <= HP_W'(ah_x) * HP_W'(coef.sin_q30);
      s3_hyc <= HP_W'(ah_y) * HP_W'(coef.cos_q30);
      s3_hys <= HP_W'(ah_y) * HP_W'(coef.sin_q30);
      s3_lxc <= LP_W'(al_x) * LP_W'(coef.cos_q30);
      s3_lxs <= LP_W'(al_x) * LP_W'(coef.sin_q30);
      s3_lyc <= LP_W'(al_y) * LP_W'(coef.cos_q30);
      s3_lys <= LP_W'(al_y) * LP_W'(coef.sin_q30);
    end
    if (a4) begin
      s4_hix <= HI_W'(s3_hxc) - HI_W'(s3_hys);
      s4_lox <= LO_W'(s3_lxc) - LO_W'(s3_lys);
      s4_hiy <= HI_W'(s3_hxs) + HI_W'(s3_hyc);
      s4_loy <= LO_W'(s3_lxs) + LO_W'(s3_lyc);
    end
    if (a5) begin
      s5_tx <= T_W'(s4_hix) + T_W'(s4_lox >>> SPLIT);
      s5_ty <= T_W'(s4_hiy) + T_W'(s4_loy >>> SPLIT);
    end
    if (a6) begin
      result.result_x <= sat_x;
      result.result_y <= sat_y;
      result.overflow <= ovf_x || ovf_y;
    end
  end

endmodule

// ===== rtl/point_scale_rotate_translate_unit.sv =====
// Top level of the 2D scale-rotate-translate point transform.
//
// One point request per clock through six register stages, unless a
// sine/cosine update holds the input or the result is stalled. An accepted
// point passes registers s1 to s5 and then the result register. The stages
// are scale multiply, round, Q2.30 partial products, partial sums, merge and
// offset add with saturation; ready backs up through per-stage valid bits
// so a stalled result costs no bubble. Writing the rotation register starts
// the sine/cosine unit: restoring subtracts for the modulo-360 wrap, a fold
// step, a degree-to-radian multiply, the CORDIC iterations and a load step.
// The input is not ready while the update runs. Scale and offset writes take
// effect at once. Write configuration only with the pipeline empty. Results
// saturate to 32 bits and overflow flags a clipped coordinate.
module point_scale_rotate_translate_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [psrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psrt_pkg::COORD_W-1:0]    cfg_data,
  psrt_point_if.sink                      point,
  psrt_result_if.source                   result
);
  import psrt_pkg::*;

  `include "point_scale_rotate_translate_unit_assert.svh"

  logic [SCALE_W-1:0]        scale_x;
  logic [SCALE_W-1:0]        scale_y;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;

  trig_t trig;
  coef_t coef;
  logic  trig_start;
  logic  hold;

  // register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x  <= SCALE_W'(longint'(1) << FRAC_BITS);
      scale_y  <= SCALE_W'(longint'(1) << FRAC_BITS);
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_X:  scale_x  <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y  <= cfg_data[SCALE_W-1:0];
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle write kicks off sine/cosine
  assign trig_start = cfg_we && (cfg_index == REG_ROTATION);

  psrt_trig u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (cfg_data),
    .trig  (trig)
  );

  // no new points while sine/cosine are being recomputed
  assign hold = trig.busy || trig_start;

  assign coef.scale_x  = scale_x;
  assign coef.scale_y  = scale_y;
  assign coef.offset_x = offset_x;
  assign coef.offset_y = offset_y;
  assign coef.cos_q30  = trig.cos_q30;
  assign coef.sin_q30  = trig.sin_q30;

  psrt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .hold   (hold),
    .coef   (coef),
    .point  (point),
    .result (result)
  );

  `PSRT_ASSERT_IMP(a_no_point_during_trig, clk, rst, point.valid && point.ready,
                   !trig.busy, "point request taken while sine/cosine update")
  `PSRT_ASSERT_NXT(a_trig_starts, clk, rst, trig_start, trig.busy,
                   "angle write did not start the trig unit")
  `PSRT_ASSERT_NXT(a_coef_steady, clk, rst, !trig.busy && !trig_start,
                   $stable(trig.cos_q30) && $stable(trig.sin_q30),
                   "sine/cosine changed while trig unit idle")
  `PSRT_ASSERT_IMP(a_ovf_saturates, clk, rst, result.valid && result.overflow,
                   result.result_x == 32'sh7FFF_FFFF || result.result_x == 32'sh8000_0000 ||
                   result.result_y == 32'sh7FFF_FFFF || result.result_y == 32'sh8000_0000,
                   "overflow flagged without a clipped coordinate")

endmodule

// ===== verif/psrt_transform_checker.sv =====
`timescale 1ns / 1ps
// Point transform checker: mirrors the configuration, predicts each result and compares it.
module psrt_transform_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psrt_pkg::COORD_W-1:0]   cfg_data,
  psrt_point_if                          point,
  psrt_result_if                         result,
  output int                             mismatches,
  output int                             outstanding,
  output int                             checked,
  output int                             saturated
);
  import psrt_pkg::*;

  localparam longint TURN         = longint'(360) << FRAC_BITS;
  localparam longint HALF_TURN    = longint'(180) << FRAC_BITS;
  localparam longint QUARTER_TURN = longint'(90) << FRAC_BITS;
  localparam longint GAIN_Q30     = 652032874;
  localparam longint DEG2RAD_Q32  = 74961321;
  localparam longint HALF_LSB     = longint'(1) << (FRAC_BITS - 1);
  localparam int     MAX_PRINTS   = 100;

  // arctan(2^-i), Q2.30, truncated
  localparam longint ATAN_Q30 [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      ovf;
  } xform_out_t;

  longint     scl_x, scl_y, off_x, off_y, cos_q30, sin_q30;
  xform_out_t predicted_results [$];

  // Wrap to [-180, 180), fold to +-90, then CORDIC rotation mode.
  function automatic void load_angle(input logic signed [COORD_W-1:0] deg);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r    = longint'(deg) % TURN;
    flip = 1'b0;
    x    = GAIN_Q30;
    y    = 0;
    if (r < 0) r += TURN;
    if (r >= HALF_TURN) r -= TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1'b1;
    end
    z = (r * DEG2RAD_Q32 + (longint'(1) << (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
    for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q30[i];
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  // round_half_up((a*c + b*d) / 2^30), exact in 128 bits
  function automatic longint q30_dot(input longint a, input longint c,
                                     input longint b, input longint d);
    logic signed [127:0] wa, wb, wc, wd, acc;
    wa  = a;
    wb  = b;
    wc  = c;
    wd  = d;
    acc = wa * wc + wb * wd + (128'sd1 <<< 29);
    acc = acc >>> 30;
    return longint'(acc);
  endfunction

  function automatic logic signed [COORD_W-1:0] clip32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic xform_out_t transform_point(input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py);
    longint     sx, sy;
    bit         ovf;
    xform_out_t res;
    ovf     = 1'b0;
    sx      = (longint'(px) * scl_x + HALF_LSB) >>> FRAC_BITS;
    sy      = (longint'(py) * scl_y + HALF_LSB) >>> FRAC_BITS;
    res.x   = clip32(q30_dot(sx, cos_q30, sy, -sin_q30) + off_x, ovf);
    res.y   = clip32(q30_dot(sx, sin_q30, sy, cos_q30) + off_y, ovf);
    res.ovf = ovf;
    return res;
  endfunction

  function automatic void write_shadow(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [COORD_W-1:0] data);
    case (idx)
      REG_SCALE_X:  scl_x = longint'(data[SCALE_W-1:0]);
      REG_SCALE_Y:  scl_y = longint'(data[SCALE_W-1:0]);
      REG_ROTATION: load_angle(data);
      REG_OFFSET_X: off_x = longint'(signed'(data));
      REG_OFFSET_Y: off_y = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  task automatic report(input string what, input longint want, input longint got);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch, %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    xform_out_t want;
    if (rst) begin
      scl_x       = longint'(1) << FRAC_BITS;
      scl_y       = longint'(1) << FRAC_BITS;
      off_x       = 0;
      off_y       = 0;
      cos_q30     = longint'(1) << 30;
      sin_q30     = 0;
      mismatches  = 0;
      checked     = 0;
      saturated   = 0;
      predicted_results.delete();
    end else begin
      if (cfg_we) write_shadow(cfg_index, cfg_data);
      if (point.valid && point.ready)
        predicted_results.push_back(transform_point(point.point_x, point.point_y));
      if (result.valid && result.ready) begin
        if (predicted_results.size() == 0) begin
          report("result with no point pending", 0, result.result_x);
        end else begin
          want = predicted_results.pop_front();
          if (result.result_x !== want.x) report("result_x", want.x, result.result_x);
          if (result.result_y !== want.y) report("result_y", want.y, result.result_y);
          if (result.overflow !== want.ovf) report("overflow", want.ovf, result.overflow);
          if (want.ovf) saturated++;
          checked++;
        end
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

// ===== verif/tb_point_scale_rotate_translate_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the point transform: stimulus, back-pressure, watchdog and verdict.
module tb_point_scale_rotate_translate_unit;
  import psrt_pkg::*;

  localparam int IDLE_PCT     = 30;    // per-cycle idle odds on either side
  localparam int STALL_LIMIT  = 1000;  // cycles without any progress
  localparam int DRAIN_CYCLES = 20;    // well past the six-stage pipe
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_POINTS = 50;
  localparam int HOLD_CYCLES  = 80;    // long result stall, fills the pipe
  localparam int STEADY_PHASE = 3;     // no idling on either side
  localparam int HOLD_PHASE   = 7;     // receiver holds off, sender keeps pushing
  localparam int DEG          = 1 << FRAC_BITS;

  localparam logic [COORD_W-1:0] MAX_Q = 32'h7fffffff;
  localparam logic [COORD_W-1:0] MIN_Q = 32'h80000000;
  localparam logic [COORD_W-1:0] ONE_Q = 32'(DEG);

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;

  psrt_point_if  point_bus ();
  psrt_result_if result_bus ();

  int mismatches, outstanding, checked, saturated;
  int points_sent, settings_used, stall_cycles, hold_req;
  bit sender_steady, receiver_steady;

  always #2 clk = ~clk;

  point_scale_rotate_translate_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .point     (point_bus),
    .result    (result_bus)
  );

  psrt_transform_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point       (point_bus),
    .result      (result_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .saturated   (saturated)
  );

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_we || (point_bus.valid && point_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, outstanding);
      $display("** point_scale_rotate_translate_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side. A hold request keeps ready low for that many cycles,
  // counted here, while the sender keeps offering points.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        result_bus.ready <= 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end else if (receiver_steady) begin
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Coordinates: mostly full-range random, some near the origin, some corners.
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return $urandom;
    if (pick < 8) return 32'(int'($urandom_range(2097152)) - 1048576);
    case ($urandom_range(4))
      0:       return MAX_Q;
      1:       return MIN_Q;
      2:       return '0;
      3:       return '1;
      default: return ONE_Q;
    endcase
  endfunction

  // Scale: bit 31 of a full random word is dropped by the register.
  function automatic logic [COORD_W-1:0] rand_scale();
    case ($urandom_range(5))
      0:       return ONE_Q;
      1:       return '0;
      2:       return MAX_Q;
      3:       return $urandom;
      default: return $urandom_range(4 * DEG);
    endcase
  endfunction

  // Angles: right-angle multiples hit the fold edges, the rest wrap freely.
  function automatic logic [COORD_W-1:0] rand_angle();
    case ($urandom_range(3))
      0:       return 32'((int'($urandom_range(8)) - 4) * 90 * DEG);
      1:       return 32'(int'($urandom_range(800 * DEG)) - 400 * DEG);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_offset();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return 32'(int'($urandom_range(2097152)) - 1048576);
    if (pick < 8) return $urandom;
    return pick[0] ? MAX_Q : MIN_Q;
  endfunction

  // One point request; random gaps before it unless the sender runs steady.
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      point_bus.valid   <= 1'b0;
      point_bus.point_x <= $urandom;
      point_bus.point_y <= $urandom;
      @(negedge clk);
    end
    point_bus.valid   <= 1'b1;
    point_bus.point_x <= x;
    point_bus.point_y <= y;
    do @(posedge clk); while (!point_bus.ready);
    @(negedge clk);
    points_sent++;
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic drain_pipeline();
    point_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // An angle write starts the trig unit; the input stays not-ready until
  // sine and cosine are loaded, so wait for ready before going on.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_ROTATION)
      while (!point_bus.ready) @(negedge clk);
  endtask

  task automatic configure(input logic [COORD_W-1:0] sx, sy, rot, ox, oy);
    drain_pipeline();
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_ROTATION, rot);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    settings_used++;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    point_bus.valid   = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    sender_steady     = 1'b0;
    receiver_steady   = 1'b0;
    hold_req          = 0;
    points_sent       = 0;
    settings_used     = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: unit scale, exact cos/sin, so points pass through unchanged.
    send_point('0, '0);
    send_point(MAX_Q, MIN_Q);
    send_point(MIN_Q, MAX_Q);
    send_point('1, 32'd1);
    send_point(ONE_Q, -ONE_Q);
    send_point(32'h55555555, 32'haaaaaaaa);

    // Largest / zero scale, exactly 90 degrees (no fold), offsets at the rails.
    configure(MAX_Q, '0, 32'(90 * DEG), MAX_Q, MIN_Q);
    send_point(ONE_Q, ONE_Q);
    send_point(MIN_Q, MAX_Q);
    send_point('1, '1);
    send_point(32'h00012345, '0);

    // -180 degrees sits on the wrap boundary and folds.
    configure(32'(2 * DEG), 32'(DEG / 2), 32'(-180 * DEG), 32'(5 * DEG), 32'(-5 * DEG));
    send_point(MAX_Q, MAX_Q);
    send_point(32'(-3 * DEG), 32'(7 * DEG));
    send_point(MIN_Q, MIN_Q);

    // Scale written with bit 31 set (dropped); most positive angle wraps.
    configure('1, ONE_Q, MAX_Q, '0, '0);
    send_point(ONE_Q, -ONE_Q);
    send_point(32'd1, 32'hffff0000);

    // Most negative angle.
    configure(ONE_Q, ONE_Q, MIN_Q, '0, '0);
    send_point(ONE_Q, ONE_Q);
    send_point(32'(-1000 * DEG), 32'(250 * DEG));

    // Exactly -90 degrees, the other fold edge.
    configure(ONE_Q, ONE_Q, 32'(-90 * DEG), 32'(DEG / 3), '0);
    send_point(ONE_Q, 32'(2 * DEG));
    send_point(MAX_Q, MIN_Q);

    // Angle zero through the CORDIC (not the exact reset values), then writes
    // to the unused indexes, which must leave everything alone.
    configure(ONE_Q, ONE_Q, '0, '0, '0);
    for (int idx = REG_OFFSET_Y + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(idx[CFG_IDX_W-1:0], $urandom);
    send_point(ONE_Q, ONE_Q);
    send_point(MAX_Q, MAX_Q);
    send_point(32'h00000001, MIN_Q);

    // Random settings per phase; one phase without idling, one with a long
    // result stall while points keep coming.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      configure(rand_scale(), rand_scale(), rand_angle(), rand_offset(), rand_offset());
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_OFFSET_Y + 1)),
                  $urandom);
      sender_steady   = (ph == STEADY_PHASE || ph == HOLD_PHASE);
      receiver_steady = (ph == STEADY_PHASE);
      if (ph == HOLD_PHASE) hold_req = HOLD_CYCLES;
      for (int n = 0; n < PHASE_POINTS; n++)
        send_point(rand_coord(), rand_coord());
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d points under %0d register settings; %0d results checked, %0d saturated.",
             points_sent, settings_used, checked, saturated);
    $display("Included scale and offset rails, angle wrap and fold edges, and a long stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("** point_scale_rotate_translate_unit: PASSED **");
    end else begin
      $display("** point_scale_rotate_translate_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/psrt_pkg.sv
rtl/psrt_point_if.sv
rtl/psrt_result_if.sv
rtl/psrt_trig.sv
rtl/psrt_datapath.sv
rtl/point_scale_rotate_translate_unit.sv
verif/psrt_transform_checker.sv
verif/tb_point_scale_rotate_translate_unit.sv
